>>> sv/scsd_pkg.sv
// shared types, codes and constants for the sync/checksum/status deframer
`timescale 1ns / 1ps
`default_nettype none

package scsd_pkg;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic
    {
        CFG_SYNC_BYTE     = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        PUMP_UNKNOWN = 2'd0,
        PUMP_OLD     = 2'd1,
        PUMP_NEW     = 2'd2
    } pump_type_t;

    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [7:0]  STATUS_OLD      = 8'h80;
    localparam logic [7:0]  STATUS_NEW_RUN  = 8'hC1;
    localparam logic [7:0]  STATUS_NEW_STOP = 8'h81;
    localparam logic [7:0]  SYNC_RESET      = 8'h00;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

    typedef struct packed
    {
        logic [7:0]  sync_byte;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed
    {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed
    {
        logic       frame_good;
        logic [7:0] status_byte;
        logic [1:0] pump_type;
        logic       pump_running;
    } result_t;

    typedef struct packed
    {
        pump_type_t kind;
        logic       running;
    } pump_state_t;

    function automatic pump_state_t decode_status(input logic [7:0] status);
        pump_state_t ps;
        ps.kind    = PUMP_UNKNOWN;
        ps.running = 1'b0;
        if (status == STATUS_OLD)
        begin
            ps.kind = PUMP_OLD;
        end
        else if (status == STATUS_NEW_RUN)
        begin
            ps.kind    = PUMP_NEW;
            ps.running = 1'b1;
        end
        else if (status == STATUS_NEW_STOP)
        begin
            ps.kind = PUMP_NEW;
        end
        return ps;
    endfunction

endpackage

`default_nettype wire

>>> sv/scsd_in_if.sv
// input item channel: operation code and received byte
`timescale 1ns / 1ps
`default_nettype none

interface scsd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> sv/scsd_out_if.sv
// result item channel: frame flag and pump status
`timescale 1ns / 1ps
`default_nettype none

interface scsd_out_if;
    logic       valid;
    logic       ready;
    logic       frame_good;
    logic [7:0] status_byte;
    logic [1:0] pump_type;
    logic       pump_running;

    modport source (output valid, output frame_good, output status_byte,
                    output pump_type, output pump_running, input ready);
    modport sink (input valid, input frame_good, input status_byte,
                  input pump_type, input pump_running, output ready);
endinterface

`default_nettype wire

>>> sv/scsd_cfg_regs.sv
// configuration registers: sync byte and timeout
`timescale 1ns / 1ps
`default_nettype none

module scsd_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [scsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output scsd_pkg::cfg_t                          cfg
);

    scsd_pkg::cfg_t cfg_reg;
    scsd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (scsd_pkg::cfg_index_t'(cfg_index))
                scsd_pkg::CFG_SYNC_BYTE:     cfg_next.sync_byte     = cfg_data[7:0];
                scsd_pkg::CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte     <= scsd_pkg::SYNC_RESET;
            cfg_reg.timeout_ticks <= scsd_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/scsd_frame_core.sv
// frame state and combinational next-state update for one item
`timescale 1ns / 1ps
`default_nettype none

module scsd_frame_core
#(
    parameter int unsigned TICK_COUNTER_BITS = 16
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scsd_pkg::cfg_t  cfg,
    input  wire logic            update,
    input  wire scsd_pkg::item_t item,
    output scsd_pkg::result_t    result
);

    localparam int unsigned CMP_BITS = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

    typedef enum logic [1:0]
    {
        FILL_HUNT = 2'd0,
        FILL_ONE  = 2'd1,
        FILL_TWO  = 2'd2
    } fill_t;

    fill_t                        fill_reg, fill_next;
    logic [7:0]                   byte1_reg, byte1_next;
    logic [7:0]                   sum_reg, sum_next;
    logic [TICK_COUNTER_BITS-1:0] elapsed_reg, elapsed_next;
    scsd_pkg::pump_type_t         type_reg, type_next;
    logic                         running_reg, running_next;
    logic [7:0]                   status_reg, status_next;
    logic                         good;
    logic [7:0]                   sum_add;
    logic                         timed_out;
    scsd_pkg::pump_state_t        decoded;

    assign sum_add   = sum_reg + item.rx_byte;
    assign timed_out = CMP_BITS'(elapsed_reg) > CMP_BITS'(cfg.timeout_ticks);
    assign decoded   = scsd_pkg::decode_status(byte1_reg);

    always_comb
    begin
        fill_next    = fill_reg;
        byte1_next   = byte1_reg;
        sum_next     = sum_reg;
        elapsed_next = elapsed_reg;
        type_next    = type_reg;
        running_next = running_reg;
        status_next  = status_reg;
        good         = 1'b0;
        if (item.operation == scsd_pkg::OP_TICK)
        begin
            if (!(&elapsed_reg))
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end
        else
        begin
            unique case (fill_reg)
                FILL_HUNT:
                begin
                    if (item.rx_byte == cfg.sync_byte)
                    begin
                        sum_next  = item.rx_byte;
                        fill_next = FILL_ONE;
                    end
                    else
                    begin
                        sum_next = 8'd0;
                        if (timed_out)
                        begin
                            type_next    = scsd_pkg::PUMP_UNKNOWN;
                            running_next = 1'b0;
                        end
                    end
                end
                FILL_ONE:
                begin
                    byte1_next = item.rx_byte;
                    sum_next   = sum_add;
                    fill_next  = FILL_TWO;
                end
                default:
                begin
                    // frame complete: good checksum, resync from a later sync, or back to hunting
                    if (sum_add == 8'd0)
                    begin
                        good         = 1'b1;
                        status_next  = byte1_reg;
                        type_next    = decoded.kind;
                        running_next = decoded.running;
                        elapsed_next = '0;
                        fill_next    = FILL_HUNT;
                        sum_next     = 8'd0;
                    end
                    else if (byte1_reg == cfg.sync_byte)
                    begin
                        byte1_next = item.rx_byte;
                        sum_next   = byte1_reg + item.rx_byte;
                        fill_next  = FILL_TWO;
                    end
                    else if (item.rx_byte == cfg.sync_byte)
                    begin
                        sum_next  = item.rx_byte;
                        fill_next = FILL_ONE;
                    end
                    else
                    begin
                        sum_next  = 8'd0;
                        fill_next = FILL_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= FILL_HUNT;
            byte1_reg   <= 8'd0;
            sum_reg     <= 8'd0;
            elapsed_reg <= '0;
            type_reg    <= scsd_pkg::PUMP_UNKNOWN;
            running_reg <= 1'b0;
            status_reg  <= 8'd0;
        end
        else if (update)
        begin
            fill_reg    <= fill_next;
            byte1_reg   <= byte1_next;
            sum_reg     <= sum_next;
            elapsed_reg <= elapsed_next;
            type_reg    <= type_next;
            running_reg <= running_next;
            status_reg  <= status_next;
        end
    end

    assign result.frame_good   = good;
    assign result.status_byte  = status_next;
    assign result.pump_type    = type_next;
    assign result.pump_running = running_next;

endmodule

`default_nettype wire

>>> sv/sync_checksum_status_deframer.sv
// top level of the sync/checksum/status deframer
// Takes one item per cycle while results are accepted, a received byte or a timer tick,
// and returns one result item for each: whether the byte completed a good three-byte frame
// (sync, status, checksum with a zero modulo-256 sum), the last good status byte, and the
// decoded pump type and running flag. The block sustains one item per clock while the result
// side does not stall; each item is held in the input register, and its result is stored in
// the result register after the frame update. Both sides may stall freely. Write sync_byte and
// timeout_ticks through the cfg port only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module sync_checksum_status_deframer
#(
    parameter int unsigned TICK_COUNTER_BITS = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    scsd_in_if.sink                                 rx,
    scsd_out_if.source                              result,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [scsd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    scsd_pkg::cfg_t    cfg;
    scsd_pkg::item_t   stage_item_reg;
    logic              stage_valid_reg, stage_valid_next;
    scsd_pkg::result_t out_item_reg;
    logic              out_valid_reg, out_valid_next;
    scsd_pkg::result_t core_result;
    logic              advance;
    logic              rx_take;

    scsd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scsd_frame_core #(.TICK_COUNTER_BITS(TICK_COUNTER_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .update (stage_valid_reg && advance),
        .item   (stage_item_reg),
        .result (core_result)
    );

    assign advance  = !out_valid_reg || result.ready;
    assign rx.ready = !stage_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (rx_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            stage_item_reg.operation <= rx.operation;
            stage_item_reg.rx_byte   <= rx.rx_byte;
        end
        if (advance && stage_valid_reg)
        begin
            out_item_reg <= core_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_good   = out_item_reg.frame_good;
    assign result.status_byte  = out_item_reg.status_byte;
    assign result.pump_type    = out_item_reg.pump_type;
    assign result.pump_running = out_item_reg.pump_running;

`ifndef SYNTHESIS
    a_good_frame_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.frame_good |->
            {out_item_reg.pump_type, out_item_reg.pump_running} ==
                scsd_pkg::decode_status(out_item_reg.status_byte))
        else $error("good frame result does not match decoded status");

    a_running_needs_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.pump_running |->
            out_item_reg.pump_type == scsd_pkg::PUMP_NEW)
        else $error("running flag set without new pump type");

    a_stage_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && advance |=> out_valid_reg)
        else $error("item left the input register without a result");
`endif

endmodule

`default_nettype wire

>>> sim/tb_sync_checksum_status_deframer.sv
// self-checking testbench for the sync/checksum/status deframer
`timescale 1ns / 1ps

module tb_sync_checksum_status_deframer;

    localparam int TICK_BITS   = 16;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    scsd_pkg::cfg_index_t cfg_index;
    logic [scsd_pkg::CFG_DATA_BITS-1:0] cfg_data;

    scsd_in_if  rx_ch ();
    scsd_out_if res_ch ();

    sync_checksum_status_deframer #(.TICK_COUNTER_BITS(TICK_BITS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // deframer state as predicted
    logic [7:0]           m_sync;
    logic [15:0]          m_timeout;
    int                   m_fill;
    logic [7:0]           m_frame [3];
    logic [7:0]           m_sum;
    logic [TICK_BITS-1:0] m_elapsed;
    scsd_pkg::pump_type_t m_type;
    logic                 m_running;
    logic [7:0]           m_status;

    scsd_pkg::item_t   pending_items [$];
    scsd_pkg::result_t expected_results [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      send_idle_pct;
    int      recv_idle_pct;

    task automatic deframer_update(input scsd_pkg::item_t it);
        scsd_pkg::result_t r;
        int      start;
        r.frame_good = 1'b0;
        if (it.operation == scsd_pkg::OP_TICK)
        begin
            if (m_elapsed != '1)
                m_elapsed = m_elapsed + 1'b1;
        end
        else if (m_fill == 0)
        begin
            if (it.rx_byte == m_sync)
            begin
                m_frame[0] = it.rx_byte;
                m_sum      = it.rx_byte;
                m_fill     = 1;
            end
            else
            begin
                m_sum = 8'h00;
                if (m_elapsed > m_timeout)
                begin
                    m_type    = scsd_pkg::PUMP_UNKNOWN;
                    m_running = 1'b0;
                end
            end
        end
        else
        begin
            m_frame[m_fill] = it.rx_byte;
            m_sum           = m_sum + it.rx_byte;
            m_fill          = m_fill + 1;
            if (m_fill == 3)
            begin
                if (m_sum == 8'h00)
                begin
                    r.frame_good = 1'b1;
                    m_status     = m_frame[1];
                    m_running    = (m_status == scsd_pkg::STATUS_NEW_RUN);
                    if (m_status == scsd_pkg::STATUS_OLD)
                        m_type = scsd_pkg::PUMP_OLD;
                    else if (m_status == scsd_pkg::STATUS_NEW_RUN ||
                             m_status == scsd_pkg::STATUS_NEW_STOP)
                        m_type = scsd_pkg::PUMP_NEW;
                    else
                        m_type = scsd_pkg::PUMP_UNKNOWN;
                    m_elapsed = '0;
                    m_fill    = 0;
                    m_sum     = 8'h00;
                end
                else
                begin
                    // restart from the first sync byte found after the leading one
                    start = 3;
                    for (int i = 1; i < 3; i++)
                        if (start == 3 && m_frame[i] == m_sync)
                            start = i;
                    m_sum = 8'h00;
                    for (int i = 0; i + start < 3; i++)
                    begin
                        m_frame[i] = m_frame[i + start];
                        m_sum      = m_sum + m_frame[i];
                    end
                    m_fill = 3 - start;
                end
            end
        end
        r.status_byte  = m_status;
        r.pump_type    = m_type;
        r.pump_running = m_running;
        expected_results.push_back(r);
    endtask

    task automatic push_item(input scsd_pkg::op_t op, input logic [7:0] value);
        scsd_pkg::item_t it;
        it.operation = op;
        it.rx_byte   = value;
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int count);
        for (int i = 0; i < count; i++)
            push_item(scsd_pkg::OP_TICK, 8'($urandom));
    endtask

    task automatic push_frame(input logic [7:0] status, input logic [7:0] check);
        push_item(scsd_pkg::OP_BYTE, m_sync);
        push_item(scsd_pkg::OP_BYTE, status);
        push_item(scsd_pkg::OP_BYTE, check);
    endtask

    task automatic push_good_frame(input logic [7:0] status);
        push_frame(status, 8'h00 - m_sync - status);
    endtask

    task automatic push_stray_byte();
        logic [7:0] value;
        do
            value = 8'($urandom);
        while (value == m_sync);
        push_item(scsd_pkg::OP_BYTE, value);
    endtask

    task automatic write_cfg(input scsd_pkg::cfg_index_t idx,
                             input logic [scsd_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == scsd_pkg::CFG_SYNC_BYTE)
            m_sync = data[7:0];
        else
            m_timeout = data;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || rx_ch.valid || expected_results.size() != 0);
    endtask

    task automatic random_traffic(input int count);
        int         target;
        int         pick;
        logic [7:0] status;
        logic [7:0] check;
        target = pending_items.size() + count;
        while (pending_items.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                case ($urandom_range(4))
                    0: status = scsd_pkg::STATUS_OLD;
                    1: status = scsd_pkg::STATUS_NEW_RUN;
                    2: status = scsd_pkg::STATUS_NEW_STOP;
                    3: status = m_sync;
                    default: status = 8'($urandom);
                endcase
                push_good_frame(status);
            end
            else if (pick < 62)
            begin
                status = ($urandom_range(3) == 0) ? m_sync : 8'($urandom);
                check  = ($urandom_range(3) == 0) ? m_sync : 8'($urandom);
                if (8'(m_sync + status + check) == 8'h00)
                    check = check + 1'b1;
                push_frame(status, check);
            end
            else if (pick < 82)
            begin
                if (m_timeout <= 40 && $urandom_range(3) == 0)
                    push_ticks(m_timeout + 2);
                else
                    push_ticks($urandom_range(1, 3));
            end
            else
                push_item(scsd_pkg::OP_BYTE, 8'($urandom));
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        scsd_pkg::item_t seen;
        scsd_pkg::item_t next_item;
        if (!rst_n)
            rx_ch.valid <= 1'b0;
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                seen.operation = rx_ch.operation;
                seen.rx_byte   = rx_ch.rx_byte;
                deframer_update(seen);
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    rx_ch.valid     <= 1'b1;
                    rx_ch.operation <= next_item.operation;
                    rx_ch.rx_byte   <= next_item.rx_byte;
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        scsd_pkg::result_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected item expected none actual %0h/%0h/%0h/%0h",
                             $time, res_ch.frame_good, res_ch.status_byte,
                             res_ch.pump_type, res_ch.pump_running);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("frame_good", want.frame_good, res_ch.frame_good);
                    check_field("status_byte", want.status_byte, res_ch.status_byte);
                    check_field("pump_type", want.pump_type, res_ch.pump_type);
                    check_field("pump_running", want.pump_running, res_ch.pump_running);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[sync_checksum_status_deframer] ERROR");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = scsd_pkg::CFG_SYNC_BYTE;
        cfg_data        = '0;
        rx_ch.valid     = 1'b0;
        rx_ch.operation = scsd_pkg::OP_BYTE;
        rx_ch.rx_byte   = 8'h00;
        res_ch.ready    = 1'b0;
        m_sync          = scsd_pkg::SYNC_RESET;
        m_timeout       = scsd_pkg::TIMEOUT_RESET;
        m_fill          = 0;
        m_frame         = '{default: 8'h00};
        m_sum           = 8'h00;
        m_elapsed       = '0;
        m_type          = scsd_pkg::PUMP_UNKNOWN;
        m_running       = 1'b0;
        m_status        = 8'h00;
        send_idle_pct   = 11;
        recv_idle_pct   = 53;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames and corner cases
        write_cfg(scsd_pkg::CFG_SYNC_BYTE, {8'($urandom), 8'hA5});
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, 16'd1);
        push_item(scsd_pkg::OP_BYTE, 8'h00);
        push_good_frame(8'h3C);
        push_good_frame(scsd_pkg::STATUS_OLD);
        push_good_frame(scsd_pkg::STATUS_NEW_RUN);
        push_good_frame(scsd_pkg::STATUS_NEW_STOP);
        push_ticks(2);
        push_item(scsd_pkg::OP_BYTE, 8'hFF);
        // bad checksum, sync found in status position, then completed
        push_frame(8'hA5, 8'h00);
        push_item(scsd_pkg::OP_BYTE, 8'h5B);
        // bad checksum, sync found in checksum position
        push_frame(8'h12, 8'hA5);
        push_item(scsd_pkg::OP_BYTE, 8'h33);
        push_item(scsd_pkg::OP_BYTE, 8'h44);
        wait_idle();

        write_cfg(scsd_pkg::CFG_SYNC_BYTE, {8'($urandom), 8'h00});
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, 16'd0);
        random_traffic(300);
        wait_idle();
        write_cfg(scsd_pkg::CFG_SYNC_BYTE, {8'($urandom), 8'hFF});
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, scsd_pkg::TIMEOUT_RESET);
        random_traffic(300);
        wait_idle();

        send_idle_pct = 53;
        recv_idle_pct = 11;
        write_cfg(scsd_pkg::CFG_SYNC_BYTE, 16'($urandom));
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 20)));
        random_traffic(300);
        wait_idle();
        write_cfg(scsd_pkg::CFG_SYNC_BYTE, 16'($urandom));
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, 16'd5);
        random_traffic(250);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(scsd_pkg::CFG_SYNC_BYTE, 16'($urandom));
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, 16'd3);
        random_traffic(250);
        wait_idle();

        // stray bytes right at and just past a longer timeout
        write_cfg(scsd_pkg::CFG_TIMEOUT_TICKS, 16'd200);
        push_good_frame(scsd_pkg::STATUS_NEW_RUN);
        push_ticks(200);
        push_stray_byte();
        push_ticks(1);
        push_stray_byte();
        push_good_frame(scsd_pkg::STATUS_OLD);
        wait_idle();

        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[sync_checksum_status_deframer] OK");
        else
            $display("[sync_checksum_status_deframer] ERROR");
        $finish;
    end

endmodule
